>>> sv/assert_macros.svh
// assertion macros shared by the rtl of the channel state block
// each macro samples on posedge clk and is disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every enabled edge
`define ASSERT_HOLDS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/mccs_pkg.sv
// types, codes and constants of the midi channel controller state block
// used by the update logic and the top level
`default_nettype none

package mccs_pkg;

    localparam int CHANNELS   = 16;
    localparam int ADDR_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEFAULT_VOLUME     = 2'd0,
        CFG_DEFAULT_EXPRESSION = 2'd1,
        CFG_DEFAULT_BEND_RANGE = 2'd2
    } cfg_index_t;

    // message function codes
    typedef enum logic [2:0] {
        FUNC_CC      = 3'd0,
        FUNC_PROGRAM = 3'd1,
        FUNC_CHAN_AT = 3'd2,
        FUNC_BEND    = 3'd3,
        FUNC_POLY_AT = 3'd4
    } func_t;

    // result change kinds
    typedef enum logic [4:0] {
        K_NONE       = 5'd0,
        K_PROG       = 5'd1,
        K_CHAN_AT    = 5'd2,
        K_POLY_AT    = 5'd3,
        K_BEND       = 5'd4,
        K_MOD        = 5'd5,
        K_PORTA_TIME = 5'd6,
        K_VOLUME     = 5'd7,
        K_PAN        = 5'd8,
        K_EXPRESSION = 5'd9,
        K_CH_LIMIT   = 5'd10,
        K_DAMPER     = 5'd11,
        K_PORTA_ON   = 5'd12,
        K_PORTA_NOTE = 5'd13,
        K_BEND_RANGE = 5'd14,
        K_SOUND_OFF  = 5'd15,
        K_RESET_CTRL = 5'd16,
        K_NOTES_OFF  = 5'd17
    } kind_t;

    // controller numbers
    localparam logic [6:0] CC_MOD           = 7'd1;
    localparam logic [6:0] CC_PORTA_TIME    = 7'd5;
    localparam logic [6:0] CC_ENTRY_APPLY   = 7'd6;
    localparam logic [6:0] CC_VOLUME        = 7'd7;
    localparam logic [6:0] CC_PAN           = 7'd10;
    localparam logic [6:0] CC_EXPRESSION    = 7'd11;
    localparam logic [6:0] CC_ENTRY_HIGH    = 7'd38;
    localparam logic [6:0] CC_CH_LIMIT      = 7'd55;
    localparam logic [6:0] CC_DAMPER        = 7'd64;
    localparam logic [6:0] CC_PORTA_ON      = 7'd65;
    localparam logic [6:0] CC_PORTA_NOTE    = 7'd84;
    localparam logic [6:0] CC_NRPN_LOW      = 7'd98;
    localparam logic [6:0] CC_NRPN_HIGH     = 7'd99;
    localparam logic [6:0] CC_RPN_LOW       = 7'd100;
    localparam logic [6:0] CC_RPN_HIGH      = 7'd101;
    localparam logic [6:0] CC_SOUND_OFF     = 7'd120;
    localparam logic [6:0] CC_RESET_CTRL    = 7'd121;
    localparam logic [6:0] CC_NOTES_OFF     = 7'd123;

    localparam logic [6:0]  SWITCH_ON_LEVEL  = 7'd64;
    localparam logic [15:0] BEND_CENTER      = 16'd8192;
    localparam logic [14:0] PARAM_NONE       = 15'h7f7f;
    localparam logic [6:0]  PAN_CENTER       = 7'd64;
    localparam logic [6:0]  RESET_VOLUME     = 7'd100;
    localparam logic [6:0]  RESET_EXPRESSION = 7'd127;
    localparam logic [14:0] RESET_BEND_RANGE = 15'd2;

    typedef struct packed {
        logic [2:0] func;
        logic [3:0] channel;
        logic [6:0] first_data;
        logic [6:0] second_data;
    } in_item_t;

    typedef struct packed {
        logic [3:0]         out_channel;
        logic [4:0]         change_kind;
        logic signed [15:0] new_value;
        logic [6:0]         key_number;
    } out_item_t;

    typedef struct packed {
        logic [6:0]  volume;
        logic [6:0]  expression;
        logic [14:0] bend_range;
    } cfg_defaults_t;

    // one channel's stored controller state
    typedef struct packed {
        logic [6:0]  program_number;
        logic [6:0]  channel_pressure;
        logic [13:0] bend_amount;
        logic [6:0]  mod_depth;
        logic [6:0]  channel_volume;
        logic [6:0]  channel_pan;
        logic [6:0]  channel_expression;
        logic        hold_pedal;
        logic        glide_enabled;
        logic [6:0]  glide_start_key;
        logic [14:0] bend_range;
        logic [14:0] entry_word;
        logic [14:0] registered_param;
        logic [14:0] nonregistered_param;
        logic        selecting_nonregistered;
    } chan_state_t;

    localparam int STATE_W = $bits(chan_state_t);

    // state of a channel that has not been written since reset
    function automatic chan_state_t reset_state();
        chan_state_t s;
        s                     = '0;
        s.channel_volume      = RESET_VOLUME;
        s.channel_pan         = PAN_CENTER;
        s.channel_expression  = RESET_EXPRESSION;
        s.bend_range          = RESET_BEND_RANGE;
        s.registered_param    = PARAM_NONE;
        s.nonregistered_param = PARAM_NONE;
        return s;
    endfunction

endpackage

`default_nettype wire

>>> sv/mccs_if.sv
// valid/ready channel interfaces of the channel state block
// message input, result output and configuration write; uses nothing else
`default_nettype none

interface mccs_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] func;
    logic [3:0] channel;
    logic [6:0] first_data;
    logic [6:0] second_data;

    modport source (output valid, func, channel, first_data, second_data, input ready);
    modport sink   (input valid, func, channel, first_data, second_data, output ready);
endinterface

interface mccs_out_if;
    logic               valid;
    logic               ready;
    logic [3:0]         out_channel;
    logic [4:0]         change_kind;
    logic signed [15:0] new_value;
    logic [6:0]         key_number;

    modport source (output valid, out_channel, change_kind, new_value, key_number,
                    input ready);
    modport sink   (input valid, out_channel, change_kind, new_value, key_number,
                    output ready);
endinterface

interface mccs_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [14:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> sv/midi_channel_controller_state.sv
// midi channel controller state: a message word in, one result word out
// a message word is held in the read stage, then its result word in the output register
// one word per cycle unless output stalls; state is read at the accept edge, written
// back as the word leaves the read stage; the last write is forwarded to the next read
// reset: per-channel valid bits clear at once, so unwritten channels read as
// their reset values with no clearing pass; default registers return to reset
`default_nettype none
`include "assert_macros.svh"

module midi_channel_controller_state (
    input  wire logic   clk,
    input  wire logic   rst_n,
    mccs_in_if.sink     in_ch,
    mccs_out_if.source  out_ch,
    mccs_cfg_if.sink    cfg
);

    mccs_pkg::cfg_defaults_t         defaults_reg;
    mccs_pkg::in_item_t              in_item;
    logic                            in_accept;

    logic                            s1_valid_reg;
    mccs_pkg::in_item_t              s1_item_reg;
    logic                            s1_entry_valid_reg;
    logic                            s1_adv;
    logic [mccs_pkg::ADDR_W-1:0]     s1_addr;

    logic [mccs_pkg::CHANNELS-1:0]   entry_valid_reg;
    logic                            fwd_valid_reg;
    logic [mccs_pkg::ADDR_W-1:0]     fwd_addr_reg;
    mccs_pkg::chan_state_t           fwd_state_reg;

    logic [mccs_pkg::STATE_W-1:0]    ram_rdata;
    logic                            ram_we;
    mccs_pkg::chan_state_t           cur_state;
    mccs_pkg::chan_state_t           new_state;
    mccs_pkg::out_item_t             upd_res;
    logic                            upd_in_range;

    logic                            out_valid_reg;
    mccs_pkg::out_item_t             out_item_reg;

    // configuration writes, always accepted
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            defaults_reg.volume     <= mccs_pkg::RESET_VOLUME;
            defaults_reg.expression <= mccs_pkg::RESET_EXPRESSION;
            defaults_reg.bend_range <= mccs_pkg::RESET_BEND_RANGE;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                mccs_pkg::CFG_DEFAULT_VOLUME:     defaults_reg.volume     <= cfg.data[6:0];
                mccs_pkg::CFG_DEFAULT_EXPRESSION: defaults_reg.expression <= cfg.data[6:0];
                mccs_pkg::CFG_DEFAULT_BEND_RANGE: defaults_reg.bend_range <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    // input word and handshake
    assign in_item.func        = in_ch.func;
    assign in_item.channel     = in_ch.channel;
    assign in_item.first_data  = in_ch.first_data;
    assign in_item.second_data = in_ch.second_data;

    assign s1_adv      = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || s1_adv;
    assign in_accept   = in_ch.valid && in_ch.ready;
    assign s1_addr     = s1_item_reg.channel[mccs_pkg::ADDR_W-1:0];

    // channel state memory
    mccs_ram #(
        .WIDTH (mccs_pkg::STATE_W),
        .DEPTH (mccs_pkg::CHANNELS)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_addr),
        .wdata (new_state),
        .re    (in_accept),
        .raddr (in_item.channel[mccs_pkg::ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // read stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // read stage payload, valid bit sampled with the memory read
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_item_reg        <= in_item;
            s1_entry_valid_reg <= entry_valid_reg[in_item.channel[mccs_pkg::ADDR_W-1:0]];
        end
    end

    // pick forwarded, stored or reset state
    always_comb
    begin
        if (fwd_valid_reg && fwd_addr_reg == s1_addr)
        begin
            cur_state = fwd_state_reg;
        end
        else if (s1_entry_valid_reg)
        begin
            cur_state = mccs_pkg::chan_state_t'(ram_rdata);
        end
        else
        begin
            cur_state = mccs_pkg::reset_state();
        end
    end

    mccs_update u_update (
        .item     (s1_item_reg),
        .cur      (cur_state),
        .defaults (defaults_reg),
        .in_range (upd_in_range),
        .nxt      (new_state),
        .res      (upd_res)
    );

    assign ram_we = s1_adv && upd_in_range;

    // valid bits and write forwarding control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            fwd_valid_reg   <= 1'b0;
        end
        else if (ram_we)
        begin
            entry_valid_reg[s1_addr] <= 1'b1;
            fwd_valid_reg            <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            fwd_addr_reg  <= s1_addr;
            fwd_state_reg <= new_state;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_item_reg <= upd_res;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.out_channel = out_item_reg.out_channel;
    assign out_ch.change_kind = out_item_reg.change_kind;
    assign out_ch.new_value   = out_item_reg.new_value;
    assign out_ch.key_number  = out_item_reg.key_number;

    // checks
    `ASSERT_IMPLIES(a_write_on_advance, ram_we, s1_adv, "state write without stage advance")
    `ASSERT_NEXT(a_stall_keeps_stage, s1_valid_reg && !s1_adv, s1_valid_reg,
                 "stalled word lost")
    `ASSERT_IMPLIES(a_out_from_stage, $rose(out_valid_reg), $past(s1_adv),
                    "result word from nowhere")
    `ASSERT_IMPLIES(a_none_is_blank,
                    out_valid_reg && out_item_reg.change_kind == mccs_pkg::K_NONE,
                    out_item_reg.new_value == 16'sd0 && out_item_reg.key_number == 7'd0,
                    "kind none with payload")

endmodule

`default_nettype wire

>>> sv/mccs_ram.sv
// generic single write port ram with one registered read port
// no dependencies
`default_nettype none

module mccs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> sv/mccs_update.sv
// decodes one channel message against that channel's state
// gives the new state and the result word; uses mccs_pkg
`default_nettype none

module mccs_update (
    input  wire mccs_pkg::in_item_t      item,
    input  wire mccs_pkg::chan_state_t   cur,
    input  wire mccs_pkg::cfg_defaults_t defaults,
    output logic                         in_range,
    output mccs_pkg::chan_state_t        nxt,
    output mccs_pkg::out_item_t          res
);

    logic [14:0] entry_applied;
    logic [15:0] bend_value;
    logic        switch_on;

    // helpers for data entry, bend and switch controllers
    assign entry_applied = {cur.entry_word[14:8], 1'b0, item.second_data};
    assign bend_value    = {2'b00, item.second_data, item.first_data} - mccs_pkg::BEND_CENTER;
    assign switch_on     = (item.second_data >= mccs_pkg::SWITCH_ON_LEVEL);
    assign in_range      = ({1'b0, item.channel} < 5'(mccs_pkg::CHANNELS));

    // message decode
    always_comb
    begin
        nxt             = cur;
        res.out_channel = item.channel;
        res.change_kind = mccs_pkg::K_NONE;
        res.new_value   = '0;
        res.key_number  = '0;
        if (in_range)
        begin
            case (item.func)
                mccs_pkg::FUNC_CC:
                begin
                    case (item.first_data)
                        mccs_pkg::CC_MOD:
                        begin
                            nxt.mod_depth   = item.second_data;
                            res.change_kind = mccs_pkg::K_MOD;
                            res.new_value   = {9'd0, item.second_data};
                        end
                        mccs_pkg::CC_PORTA_TIME:
                        begin
                            res.change_kind = mccs_pkg::K_PORTA_TIME;
                            res.new_value   = {9'd0, item.second_data};
                        end
                        mccs_pkg::CC_VOLUME:
                        begin
                            nxt.channel_volume = item.second_data;
                            res.change_kind    = mccs_pkg::K_VOLUME;
                            res.new_value      = {9'd0, item.second_data};
                        end
                        mccs_pkg::CC_PAN:
                        begin
                            nxt.channel_pan = item.second_data;
                            res.change_kind = mccs_pkg::K_PAN;
                            res.new_value   = {9'd0, item.second_data};
                        end
                        mccs_pkg::CC_EXPRESSION:
                        begin
                            nxt.channel_expression = item.second_data;
                            res.change_kind        = mccs_pkg::K_EXPRESSION;
                            res.new_value          = {9'd0, item.second_data};
                        end
                        mccs_pkg::CC_CH_LIMIT:
                        begin
                            res.change_kind = mccs_pkg::K_CH_LIMIT;
                            res.new_value   = {9'd0, item.second_data};
                        end
                        mccs_pkg::CC_DAMPER:
                        begin
                            nxt.hold_pedal  = switch_on;
                            res.change_kind = mccs_pkg::K_DAMPER;
                            res.new_value   = {15'd0, switch_on};
                        end
                        mccs_pkg::CC_PORTA_ON:
                        begin
                            nxt.glide_enabled = switch_on;
                            res.change_kind   = mccs_pkg::K_PORTA_ON;
                            res.new_value     = {15'd0, switch_on};
                        end
                        mccs_pkg::CC_PORTA_NOTE:
                        begin
                            nxt.glide_start_key = item.second_data;
                            res.change_kind     = mccs_pkg::K_PORTA_NOTE;
                            res.new_value       = {9'd0, item.second_data};
                        end
                        mccs_pkg::CC_ENTRY_APPLY:
                        begin
                            // rpn 0 selected: the word becomes the bend range
                            nxt.entry_word = entry_applied;
                            if (!cur.selecting_nonregistered && cur.registered_param == '0)
                            begin
                                nxt.bend_range  = entry_applied;
                                res.change_kind = mccs_pkg::K_BEND_RANGE;
                                res.new_value   = {1'b0, entry_applied};
                            end
                        end
                        mccs_pkg::CC_ENTRY_HIGH:
                        begin
                            nxt.entry_word = {item.second_data, cur.entry_word[7:0]};
                        end
                        mccs_pkg::CC_NRPN_LOW:
                        begin
                            nxt.nonregistered_param =
                                {cur.nonregistered_param[14:8], 1'b0, item.second_data};
                            nxt.selecting_nonregistered = 1'b1;
                        end
                        mccs_pkg::CC_NRPN_HIGH:
                        begin
                            nxt.nonregistered_param =
                                {item.second_data, cur.nonregistered_param[7:0]};
                            nxt.selecting_nonregistered = 1'b1;
                        end
                        mccs_pkg::CC_RPN_LOW:
                        begin
                            nxt.registered_param =
                                {cur.registered_param[14:8], 1'b0, item.second_data};
                            nxt.selecting_nonregistered = 1'b0;
                        end
                        mccs_pkg::CC_RPN_HIGH:
                        begin
                            nxt.registered_param =
                                {item.second_data, cur.registered_param[7:0]};
                            nxt.selecting_nonregistered = 1'b0;
                        end
                        mccs_pkg::CC_SOUND_OFF:
                        begin
                            res.change_kind = mccs_pkg::K_SOUND_OFF;
                        end
                        mccs_pkg::CC_RESET_CTRL:
                        begin
                            // pan, volume, program and rpn select are kept
                            nxt.bend_amount        = '0;
                            nxt.mod_depth          = '0;
                            nxt.bend_range         = defaults.bend_range;
                            nxt.channel_expression = defaults.expression;
                            nxt.glide_enabled      = 1'b0;
                            nxt.glide_start_key    = '0;
                            nxt.hold_pedal         = 1'b0;
                            res.change_kind        = mccs_pkg::K_RESET_CTRL;
                        end
                        mccs_pkg::CC_NOTES_OFF:
                        begin
                            res.change_kind = mccs_pkg::K_NOTES_OFF;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                mccs_pkg::FUNC_PROGRAM:
                begin
                    nxt.program_number = item.first_data;
                    res.change_kind    = mccs_pkg::K_PROG;
                    res.new_value      = {9'd0, item.first_data};
                end
                mccs_pkg::FUNC_CHAN_AT:
                begin
                    nxt.channel_pressure = item.first_data;
                    res.change_kind      = mccs_pkg::K_CHAN_AT;
                    res.new_value        = {9'd0, item.first_data};
                end
                mccs_pkg::FUNC_BEND:
                begin
                    nxt.bend_amount = bend_value[13:0];
                    res.change_kind = mccs_pkg::K_BEND;
                    res.new_value   = bend_value;
                end
                mccs_pkg::FUNC_POLY_AT:
                begin
                    res.change_kind = mccs_pkg::K_POLY_AT;
                    res.new_value   = {9'd0, item.second_data};
                    res.key_number  = item.first_data;
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// self-checking bench for midi_channel_controller_state: directed messages, then random
// traffic in phases with default register writes in between; needs mccs_pkg and mccs_if
`timescale 1ns / 1ps

module tb_top;
    import mccs_pkg::*;

    localparam int          RANDOM_PHASES    = 6;
    localparam int          WORDS_PER_PHASE  = 300;
    localparam int          SETTLE_CYCLES    = 6;
    localparam logic [2:0]  FUNC_UNUSED      = 3'd7;
    localparam logic [1:0]  CFG_UNUSED_INDEX = 2'd3;
    localparam int          BEND_OFFSET      = 8192;

    typedef struct {
        in_item_t  msg;
        bit        typed;
        out_item_t want;
    } directed_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    mccs_in_if  in_bus ();
    mccs_out_if out_bus ();
    mccs_cfg_if cfg_bus ();

    midi_channel_controller_state i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_bus),
        .out_ch (out_bus),
        .cfg    (cfg_bus)
    );

    // shadow copy of the per-channel state and the default registers
    chan_state_t   chan_shadow [CHANNELS];
    cfg_defaults_t cfg_shadow;
    out_item_t     expected_results [$];
    directed_row_t directed_rows [$];

    int  errors       = 0;
    int  words_sent   = 0;
    int  words_seen   = 0;
    int  cfg_writes   = 0;
    int  bend_ranges  = 0;
    bit  steady       = 1'b0;

    always #1 clk = ~clk;

    // idle length: mostly none, some short, a few long
    function automatic int idle_len();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    function automatic void reset_shadow();
        cfg_shadow.volume     = RESET_VOLUME;
        cfg_shadow.expression = RESET_EXPRESSION;
        cfg_shadow.bend_range = RESET_BEND_RANGE;
        for (int c = 0; c < CHANNELS; c++)
        begin
            chan_shadow[c]                     = '0;
            chan_shadow[c].channel_volume      = cfg_shadow.volume;
            chan_shadow[c].channel_pan         = PAN_CENTER;
            chan_shadow[c].channel_expression  = cfg_shadow.expression;
            chan_shadow[c].bend_range          = cfg_shadow.bend_range;
            chan_shadow[c].registered_param    = PARAM_NONE;
            chan_shadow[c].nonregistered_param = PARAM_NONE;
        end
    endfunction

    // apply one message to the shadow state and return the result word it gives
    function automatic out_item_t controller_update(in_item_t m);
        out_item_t   res;
        kind_t       kind;
        int          val;
        logic [6:0]  key;
        logic [6:0]  d1;
        logic [6:0]  d2;
        chan_state_t s;
        kind = K_NONE;
        val  = 0;
        key  = '0;
        d1   = m.first_data;
        d2   = m.second_data;
        s    = chan_shadow[m.channel];
        if (m.channel < CHANNELS)
        begin
            case (m.func)
                FUNC_CC:
                begin
                    case (d1)
                        CC_MOD:
                        begin
                            s.mod_depth = d2; kind = K_MOD; val = int'(d2);
                        end
                        CC_PORTA_TIME:
                        begin
                            kind = K_PORTA_TIME; val = int'(d2);
                        end
                        CC_VOLUME:
                        begin
                            s.channel_volume = d2; kind = K_VOLUME; val = int'(d2);
                        end
                        CC_PAN:
                        begin
                            s.channel_pan = d2; kind = K_PAN; val = int'(d2);
                        end
                        CC_EXPRESSION:
                        begin
                            s.channel_expression = d2; kind = K_EXPRESSION; val = int'(d2);
                        end
                        CC_CH_LIMIT:
                        begin
                            kind = K_CH_LIMIT; val = int'(d2);
                        end
                        CC_DAMPER:
                        begin
                            s.hold_pedal = (d2 >= SWITCH_ON_LEVEL);
                            kind = K_DAMPER; val = int'(s.hold_pedal);
                        end
                        CC_PORTA_ON:
                        begin
                            s.glide_enabled = (d2 >= SWITCH_ON_LEVEL);
                            kind = K_PORTA_ON; val = int'(s.glide_enabled);
                        end
                        CC_PORTA_NOTE:
                        begin
                            s.glide_start_key = d2; kind = K_PORTA_NOTE; val = int'(d2);
                        end
                        // low byte of data entry applies the word under rpn 0
                        CC_ENTRY_APPLY:
                        begin
                            s.entry_word = {s.entry_word[14:8], 1'b0, d2};
                            if (!s.selecting_nonregistered && s.registered_param == '0)
                            begin
                                s.bend_range = s.entry_word;
                                kind = K_BEND_RANGE; val = int'(s.bend_range);
                            end
                        end
                        CC_ENTRY_HIGH:
                            s.entry_word = {d2, s.entry_word[7:0]};
                        CC_NRPN_LOW:
                        begin
                            s.nonregistered_param = {s.nonregistered_param[14:8], 1'b0, d2};
                            s.selecting_nonregistered = 1'b1;
                        end
                        CC_NRPN_HIGH:
                        begin
                            s.nonregistered_param = {d2, s.nonregistered_param[7:0]};
                            s.selecting_nonregistered = 1'b1;
                        end
                        CC_RPN_LOW:
                        begin
                            s.registered_param = {s.registered_param[14:8], 1'b0, d2};
                            s.selecting_nonregistered = 1'b0;
                        end
                        CC_RPN_HIGH:
                        begin
                            s.registered_param = {d2, s.registered_param[7:0]};
                            s.selecting_nonregistered = 1'b0;
                        end
                        CC_SOUND_OFF:
                            kind = K_SOUND_OFF;
                        // reset-all-controllers keeps pan, volume and program
                        CC_RESET_CTRL:
                        begin
                            s.bend_amount        = '0;
                            s.mod_depth          = '0;
                            s.bend_range         = cfg_shadow.bend_range;
                            s.channel_expression = cfg_shadow.expression;
                            s.glide_enabled      = 1'b0;
                            s.glide_start_key    = '0;
                            s.hold_pedal         = 1'b0;
                            kind = K_RESET_CTRL;
                        end
                        CC_NOTES_OFF:
                            kind = K_NOTES_OFF;
                        default:
                            ;
                    endcase
                end
                FUNC_PROGRAM:
                begin
                    s.program_number = d1; kind = K_PROG; val = int'(d1);
                end
                FUNC_CHAN_AT:
                begin
                    s.channel_pressure = d1; kind = K_CHAN_AT; val = int'(d1);
                end
                FUNC_BEND:
                begin
                    val = int'({d2, d1}) - BEND_OFFSET;
                    s.bend_amount = val[13:0];
                    kind = K_BEND;
                end
                FUNC_POLY_AT:
                begin
                    kind = K_POLY_AT; val = int'(d2); key = d1;
                end
                default:
                    ;
            endcase
        end
        chan_shadow[m.channel] = s;
        res.out_channel = m.channel;
        res.change_kind = kind;
        res.new_value   = val[15:0];
        res.key_number  = key;
        return res;
    endfunction

    // append one row to the directed table
    function automatic void add_row(logic [2:0] f, int ch, int d1, int d2,
                                    bit typed, kind_t k, int v, int key);
        directed_row_t r;
        r.msg.func         = f;
        r.msg.channel      = ch[3:0];
        r.msg.first_data   = d1[6:0];
        r.msg.second_data  = d2[6:0];
        r.typed            = typed;
        r.want.out_channel = ch[3:0];
        r.want.change_kind = k;
        r.want.new_value   = v[15:0];
        r.want.key_number  = key[6:0];
        directed_rows      = {directed_rows, r};
    endfunction

    // offer one message word and queue its expected result once it is taken
    task automatic send_msg(input in_item_t m, input bit typed, input out_item_t want);
        int        gap;
        out_item_t predicted;
        gap = idle_len();
        if (gap > 0)
        begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_bus.valid       <= 1'b1;
        in_bus.func        <= m.func;
        in_bus.channel     <= m.channel;
        in_bus.first_data  <= m.first_data;
        in_bus.second_data <= m.second_data;
        do
            @(posedge clk);
        while (!in_bus.ready);
        predicted = controller_update(m);
        expected_results = {expected_results, typed ? want : predicted};
        words_sent++;
    endtask

    task automatic send_plain(input logic [2:0] f, input logic [3:0] ch,
                              input logic [6:0] d1, input logic [6:0] d2);
        in_item_t m;
        m.func        = f;
        m.channel     = ch;
        m.first_data  = d1;
        m.second_data = d2;
        send_msg(m, 1'b0, '0);
    endtask

    // stop offering words and let the pipeline empty
    task automatic drain();
        in_bus.valid <= 1'b0;
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [14:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        case (idx)
            CFG_DEFAULT_VOLUME:     cfg_shadow.volume     = value[6:0];
            CFG_DEFAULT_EXPRESSION: cfg_shadow.expression = value[6:0];
            CFG_DEFAULT_BEND_RANGE: cfg_shadow.bend_range = value;
            default:                ;
        endcase
        cfg_writes++;
    endtask

    function automatic logic [6:0] pick_known_cc();
        case ($urandom_range(17))
            0:       return CC_MOD;
            1:       return CC_PORTA_TIME;
            2:       return CC_ENTRY_APPLY;
            3:       return CC_VOLUME;
            4:       return CC_PAN;
            5:       return CC_EXPRESSION;
            6:       return CC_ENTRY_HIGH;
            7:       return CC_CH_LIMIT;
            8:       return CC_DAMPER;
            9:       return CC_PORTA_ON;
            10:      return CC_PORTA_NOTE;
            11:      return CC_NRPN_LOW;
            12:      return CC_NRPN_HIGH;
            13:      return CC_RPN_LOW;
            14:      return CC_RPN_HIGH;
            15:      return CC_SOUND_OFF;
            16:      return CC_RESET_CTRL;
            default: return CC_NOTES_OFF;
        endcase
    endfunction

    // parameter select then data entry, sometimes missing its high select
    task automatic param_sequence();
        logic [3:0] ch;
        logic [6:0] num_hi;
        logic [6:0] num_lo;
        bit         use_nrpn;
        ch       = 4'($urandom_range(CHANNELS - 1));
        use_nrpn = ($urandom_range(3) == 0);
        num_hi   = ($urandom_range(3) == 0) ? 7'($urandom_range(127)) : 7'd0;
        num_lo   = ($urandom_range(3) == 0) ? 7'($urandom_range(127)) : 7'd0;
        if ($urandom_range(4) != 0)
            send_plain(FUNC_CC, ch, use_nrpn ? CC_NRPN_HIGH : CC_RPN_HIGH, num_hi);
        send_plain(FUNC_CC, ch, use_nrpn ? CC_NRPN_LOW : CC_RPN_LOW, num_lo);
        send_plain(FUNC_CC, ch, CC_ENTRY_HIGH, 7'($urandom_range(127)));
        send_plain(FUNC_CC, ch, CC_ENTRY_APPLY, 7'($urandom_range(127)));
    endtask

    task automatic random_traffic();
        int         r;
        logic [3:0] ch;
        r  = $urandom_range(99);
        ch = 4'($urandom_range(CHANNELS - 1));
        if (r < 30)
            send_plain(3'($urandom_range(FUNC_POLY_AT)), ch, 7'($urandom_range(127)),
                       7'($urandom_range(127)));
        else if (r < 55)
            send_plain(FUNC_CC, ch, pick_known_cc(), 7'($urandom_range(127)));
        else if (r < 75)
            param_sequence();
        else if (r < 82)
            send_plain(FUNC_CC, ch, CC_RESET_CTRL, 7'($urandom_range(127)));
        else if (r < 92)
            send_plain(FUNC_CC, ch, 7'($urandom_range(127)), 7'($urandom_range(127)));
        else
            send_plain(3'($urandom_range(FUNC_UNUSED, FUNC_POLY_AT + 1)), ch,
                       7'($urandom_range(127)), 7'($urandom_range(127)));
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // result side: compare each accepted word with the oldest expectation
    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n && out_bus.valid && out_bus.ready)
        begin
            words_seen++;
            if (expected_results.size() == 0)
            begin
                $display("%0t: extra result, expected none, got ch %0d kind %0d val %0d key %0d",
                         $time, out_bus.out_channel, out_bus.change_kind,
                         out_bus.new_value, out_bus.key_number);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (want.change_kind == K_BEND_RANGE)
                    bend_ranges++;
                check_field("out_channel", int'(want.out_channel),
                            int'(out_bus.out_channel));
                check_field("change_kind", int'(want.change_kind),
                            int'(out_bus.change_kind));
                check_field("new_value", int'(want.new_value), int'(out_bus.new_value));
                check_field("key_number", int'(want.key_number), int'(out_bus.key_number));
            end
        end
    end

    // result side back pressure
    initial
    begin : result_stall
        int hold;
        int run;
        out_bus.ready <= 1'b0;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            hold = idle_len();
            if (hold > 0)
            begin
                out_bus.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_bus.ready <= 1'b1;
            run = $urandom_range(12, 1);
            repeat (run) @(posedge clk);
        end
    end

    // stimulus
    initial
    begin : stimulus
        int            phase_start;
        in_bus.valid       <= 1'b0;
        in_bus.func        <= FUNC_CC;
        in_bus.channel     <= '0;
        in_bus.first_data  <= '0;
        in_bus.second_data <= '0;
        cfg_bus.valid      <= 1'b0;
        cfg_bus.index      <= CFG_DEFAULT_VOLUME;
        cfg_bus.data       <= '0;
        reset_shadow();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed messages: field extremes, each function, every controller but nrpn high and the special cases
        add_row(FUNC_BEND, 0, 0, 0, 1'b1, K_BEND, -8192, 0);
        add_row(FUNC_BEND, 15, 127, 127, 1'b1, K_BEND, 8191, 0);
        add_row(FUNC_PROGRAM, 3, 127, 0, 1'b1, K_PROG, 127, 0);
        add_row(FUNC_CHAN_AT, 5, 0, 127, 1'b1, K_CHAN_AT, 0, 0);
        add_row(FUNC_POLY_AT, 7, 127, 127, 1'b1, K_POLY_AT, 127, 127);
        add_row(FUNC_CC, 1, CC_MOD, 127, 1'b0, K_NONE, 0, 0);
        add_row(FUNC_CC, 2, CC_PORTA_TIME, 85, 1'b0, K_NONE, 0, 0);
        add_row(FUNC_CC, 4, CC_VOLUME, 0, 1'b0, K_NONE, 0, 0);
        add_row(FUNC_CC, 6, CC_PAN, 127, 1'b0, K_NONE, 0, 0);
        add_row(FUNC_CC, 8, CC_EXPRESSION, 0, 1'b0, K_NONE, 0, 0);
        add_row(FUNC_CC, 10, CC_CH_LIMIT, 127, 1'b0, K_NONE, 0, 0);
        add_row(FUNC_CC, 11, CC_DAMPER, 63, 1'b1, K_DAMPER, 0, 0);
        add_row(FUNC_CC, 11, CC_DAMPER, 64, 1'b1, K_DAMPER, 1, 0);
        add_row(FUNC_CC, 12, CC_PORTA_ON, 127, 1'b1, K_PORTA_ON, 1, 0);
        add_row(FUNC_CC, 13, CC_PORTA_NOTE, 0, 1'b0, K_NONE, 0, 0);
        // data entry with no parameter selected does nothing visible
        add_row(FUNC_CC, 14, CC_ENTRY_APPLY, 5, 1'b1, K_NONE, 0, 0);
        add_row(FUNC_CC, 14, CC_RPN_HIGH, 0, 1'b1, K_NONE, 0, 0);
        add_row(FUNC_CC, 14, CC_RPN_LOW, 0, 1'b1, K_NONE, 0, 0);
        add_row(FUNC_CC, 14, CC_ENTRY_HIGH, 127, 1'b1, K_NONE, 0, 0);
        add_row(FUNC_CC, 14, CC_ENTRY_APPLY, 127, 1'b0, K_NONE, 0, 0);
        // nrpn select turns the bend range update off
        add_row(FUNC_CC, 14, CC_NRPN_LOW, 0, 1'b1, K_NONE, 0, 0);
        add_row(FUNC_CC, 14, CC_ENTRY_APPLY, 1, 1'b1, K_NONE, 0, 0);
        add_row(FUNC_CC, 2, CC_RESET_CTRL, 99, 1'b1, K_RESET_CTRL, 0, 0);
        add_row(FUNC_CC, 2, CC_SOUND_OFF, 0, 1'b1, K_SOUND_OFF, 0, 0);
        add_row(FUNC_CC, 2, CC_NOTES_OFF, 127, 1'b1, K_NOTES_OFF, 0, 0);
        add_row(FUNC_UNUSED, 3, 127, 127, 1'b1, K_NONE, 0, 0);
        foreach (directed_rows[i])
            send_msg(directed_rows[i].msg, directed_rows[i].typed, directed_rows[i].want);

        // random phases, each under its own default register setting
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain();
            if (phase == 0)
            begin
                write_reg(CFG_DEFAULT_VOLUME, '0);
                write_reg(CFG_DEFAULT_EXPRESSION, '0);
                write_reg(CFG_DEFAULT_BEND_RANGE, '0);
            end
            else if (phase == 1)
            begin
                write_reg(CFG_DEFAULT_VOLUME, 15'd127);
                write_reg(CFG_DEFAULT_EXPRESSION, 15'd127);
                write_reg(CFG_DEFAULT_BEND_RANGE, 15'h7fff);
            end
            else
            begin
                if (phase == 3)
                    write_reg(CFG_UNUSED_INDEX, 15'($urandom_range(32767)));
                write_reg(CFG_DEFAULT_VOLUME, 15'($urandom_range(127)));
                write_reg(CFG_DEFAULT_EXPRESSION, 15'($urandom_range(127)));
                write_reg(CFG_DEFAULT_BEND_RANGE, 15'($urandom_range(32767)));
            end
            cfg_bus.valid <= 1'b0;
            steady = (phase == 2);
            phase_start = words_sent;
            while (words_sent - phase_start < WORDS_PER_PHASE)
                random_traffic();
        end

        drain();
        if (expected_results.size() != 0)
            errors++;
        $display("run covered %0d message words and %0d result words, %0d of them bend range",
                 words_sent, words_seen, bend_ranges);
        $display("%0d default register writes over %0d random phases", cfg_writes,
                 RANDOM_PHASES);
        if (errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("tb_top failed");
        $finish;
    end

endmodule
